FILE: sv/skvt_pkg.sv
`default_nettype none

package skvt_pkg;

  localparam int unsigned KeyWidth   = 32;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CountWidth = 5;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_LOOKUP = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  // One entry as it moves between neighboring cells
  typedef struct packed {
    logic                         valid;
    logic signed [KeyWidth-1:0]   key;
    logic signed [ValueWidth-1:0] value;
  } slot_t;

  // Broadcast command to every cell
  typedef struct packed {
    logic ins;
    logic rem;
    logic clr;
  } cmd_t;

endpackage

`default_nettype wire

FILE: sv/sorted_key_value_table_unit.sv
// Sorted key/value table built as a row of CAPACITY compare-and-shift cells.
// Input channel (in_valid_i/in_ready_o) carries one request: func_i selects
// insert, remove, lookup or clear; key_i and value_i are its operands.
// Every cell compares its entry with the broadcast key in the accept cycle
// and the whole row shifts up (insert) or down (remove) at that same edge.
// Output channel (out_valid_o/out_ready_i) returns one result per request:
// hit and data of the matching entry before the request, insert status,
// entry count and the smallest and largest entries after the request.
// out_valid_o rises once a result has moved from the pending result stage
// into the output register. One request per cycle is sustained while the
// receiver takes results: the broadcast compare and the shift of the whole
// cell row at the accept edge set this rate.
// A pending result stage sits between the row and the output register, so a
// new request is still taken while one result waits at the output; with the
// receiver stalled and both stages full, in_ready_o drops and the table holds.
// Reset empties the table (all cell valid bits cleared) and drops any
// pending result; no clearing pass is needed.
`default_nettype none

module sorted_key_value_table_unit import skvt_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  [1:0]                   func_i,
  input  wire  signed [KeyWidth-1:0]   key_i,
  input  wire  signed [ValueWidth-1:0] value_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic                         hit_o,
  output logic signed [ValueWidth-1:0] hit_value_o,
  output logic                         stored_o,
  output logic                         refused_full_o,
  output logic [CountWidth-1:0]        entry_count_o,
  output logic signed [KeyWidth-1:0]   smallest_key_o,
  output logic signed [ValueWidth-1:0] smallest_value_o,
  output logic signed [KeyWidth-1:0]   largest_key_o,
  output logic signed [ValueWidth-1:0] largest_value_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  slot_t                 slot      [CAPACITY];
  slot_t                 prev_slot [CAPACITY];
  slot_t                 next_slot [CAPACITY];
  logic [CAPACITY-1:0]   less;
  logic [CAPACITY-1:0]   eq;
  logic [CAPACITY-1:0]   prev_less;
  logic [CAPACITY-1:0]   is_last;
  cmd_t                  cmd;

  func_e                 func;
  logic                  accept;
  logic                  hit;
  logic                  full;
  logic signed [ValueWidth-1:0] hit_value;
  logic signed [KeyWidth-1:0]   last_key;
  logic signed [ValueWidth-1:0] last_value;

  logic [CntW-1:0]       count_q, count_d;
  logic [CntW+CountWidth-1:0] count_ext;

  logic                  pend_valid_q;
  logic                  pend_hit_q;
  logic signed [ValueWidth-1:0] pend_hit_value_q;
  logic                  pend_stored_q;
  logic                  pend_refused_q;
  logic                  pend_move;

  assign func   = func_e'(func_i);
  assign accept = in_valid_i && in_ready_o;

  assign pend_move  = pend_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !pend_valid_q || pend_move;

  assign hit  = |eq;
  assign full = slot[CAPACITY-1].valid;

  always_comb begin
    cmd.ins = 1'b0;
    cmd.rem = 1'b0;
    cmd.clr = 1'b0;
    if (accept) begin
      unique case (func)
        FUNC_INSERT: cmd.ins = !hit && !full;
        FUNC_REMOVE: cmd.rem = hit;
        FUNC_LOOKUP: ;
        FUNC_CLEAR:  cmd.clr = 1'b1;
        default:     ;
      endcase
    end
  end

  // Keys are unique, so at most one cell matches
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (eq[i]) hit_value = hit_value | slot[i].value;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_slot[i] = '0;
      assign prev_less[i] = 1'b1;
    end else begin : g_body
      assign prev_slot[i] = slot[i-1];
      assign prev_less[i] = less[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_slot[i] = '0;
      assign is_last[i]   = slot[i].valid;
    end else begin : g_mid
      assign next_slot[i] = slot[i+1];
      assign is_last[i]   = slot[i].valid && !slot[i+1].valid;
    end

    skvt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .key_i       (key_i),
      .value_i     (value_i),
      .prev_i      (prev_slot[i]),
      .prev_less_i (prev_less[i]),
      .next_i      (next_slot[i]),
      .slot_o      (slot[i]),
      .less_o      (less[i]),
      .eq_o        (eq[i])
    );
  end

  always_comb begin
    last_key   = '0;
    last_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (is_last[i]) begin
        last_key   = last_key | slot[i].key;
        last_value = last_value | slot[i].value;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    priority if (cmd.clr) begin
      count_d = '0;
    end else if (cmd.ins) begin
      count_d = count_q + CntW'(1);
    end else if (cmd.rem) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_o  <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        pend_valid_q <= 1'b1;
      end else if (pend_move) begin
        pend_valid_q <= 1'b0;
      end
      if (pend_move) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Hit status comes from the table before the request is applied
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_hit_q       <= hit && (func != FUNC_CLEAR);
      pend_hit_value_q <= (func != FUNC_CLEAR) ? hit_value : '0;
      pend_stored_q    <= cmd.ins;
      pend_refused_q   <= (func == FUNC_INSERT) && !hit && full;
    end
  end

  assign count_ext = {{CountWidth{1'b0}}, count_q};

  // Row already holds the post-request contents when the result moves out
  always_ff @(posedge clk_i) begin
    if (pend_move) begin
      hit_o            <= pend_hit_q;
      hit_value_o      <= pend_hit_value_q;
      stored_o         <= pend_stored_q;
      refused_full_o   <= pend_refused_q;
      entry_count_o    <= count_ext[CountWidth-1:0];
      smallest_key_o   <= slot[0].valid ? slot[0].key : '0;
      smallest_value_o <= slot[0].valid ? slot[0].value : '0;
      largest_key_o    <= last_key;
      largest_value_o  <= last_value;
    end
  end

endmodule

`default_nettype wire

FILE: sv/skvt_cell.sv
`default_nettype none

module skvt_cell import skvt_pkg::*; (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  cmd_t                         cmd_i,
  input  logic signed [KeyWidth-1:0]   key_i,
  input  logic signed [ValueWidth-1:0] value_i,
  input  slot_t                        prev_i,
  input  logic                         prev_less_i,
  input  slot_t                        next_i,
  output slot_t                        slot_o,
  output logic                         less_o,
  output logic                         eq_o
);

  logic                         valid_q, valid_d;
  logic signed [KeyWidth-1:0]   key_q, key_d;
  logic signed [ValueWidth-1:0] value_q, value_d;

  assign less_o = valid_q && (key_q < key_i);
  assign eq_o   = valid_q && (key_q == key_i);
  assign slot_o = '{valid: valid_q, key: key_q, value: value_q};

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    priority if (cmd_i.clr) begin
      valid_d = 1'b0;
    end else if (cmd_i.ins && !less_o) begin
      // first cell not below the key takes the new pair, the rest shift up
      if (prev_less_i) begin
        valid_d = 1'b1;
        key_d   = key_i;
        value_d = value_i;
      end else begin
        valid_d = prev_i.valid;
        key_d   = prev_i.key;
        value_d = prev_i.value;
      end
    end else if (cmd_i.rem && !less_o) begin
      // matching cell and everything above it shift down
      valid_d = next_i.valid;
      key_d   = next_i.key;
      value_d = next_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

endmodule

`default_nettype wire
